>>> rtl/msr_pkg.sv
// Shared constants, types and a helper function of the three-phase sample reassembler.
`timescale 1ns / 1ps

package msr_pkg;

    // Geometry of one collection.
    localparam int PHASES            = 3;
    localparam int SAMPLES_PER_PHASE = 200;
    localparam int FRAMES_PER_PHASE  = 7;
    localparam int SLOTS_PER_FRAME   = 31;
    localparam int LAST_FRAME_SLOTS  = 29;

    // Field widths fixed by the interface.
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int SLOT_W   = 5;
    localparam int DATA_W   = 16;
    localparam int COUNT_W  = 3;

    // Derived sizes.
    localparam int STORE_DEPTH = PHASES * SAMPLES_PER_PHASE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PH_W        = $clog2(PHASES);
    localparam int FIDX_W      = (FRAMES_PER_PHASE > 1) ? $clog2(FRAMES_PER_PHASE) : 1;
    localparam int IDX_W       = $clog2(FRAMES_PER_PHASE * SLOTS_PER_FRAME + 32);

    typedef logic [FRAMES_PER_PHASE-1:0] frame_mask_t;
    typedef logic [COUNT_W-1:0]          frame_count_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    // First store address of a phase.
    function automatic logic [ADDR_W-1:0] phase_base(input logic [PH_W-1:0] p);
        return ADDR_W'(int'(p) * SAMPLES_PER_PHASE);
    endfunction

endpackage

>>> rtl/multi_frame_sample_reassembler_top.sv
// Top level of the three-phase sample reassembler.
`timescale 1ns / 1ps

// The block rebuilds three phases of 200 samples each from numbered frames and takes one
// beat per clock cycle while item_stall is low, giving one result beat per input beat, in
// order, through the s1 stage and the output register. Samples land in a collection RAM;
// once all frames of all phases are marked, the block copies the whole collection into a
// snapshot RAM. That copy runs through the collection RAM's single read port one entry per
// cycle, so the beat that completes the collection is followed by a copy that holds
// item_stall high; the completing beat's own result is delivered meanwhile. A restart beat
// clears the frame marks, counts and ready flag but keeps both RAMs. Read beats return
// snapshot samples; before the first completion after reset the snapshot reads as zero.
// Each channel moves a beat at a rising edge where valid is high and stall is low.
module multi_frame_sample_reassembler_top (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [msr_pkg::KIND_W-1:0]    kind,
    input  logic [msr_pkg::BYTE_W-1:0]    phase,
    input  logic [msr_pkg::BYTE_W-1:0]    sequence_req,
    input  logic [msr_pkg::SLOT_W-1:0]    slot,
    input  logic [msr_pkg::DATA_W-1:0]    sample,
    input  logic                          last_of_frame,
    input  logic [msr_pkg::BYTE_W-1:0]    read_index,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [msr_pkg::DATA_W-1:0]    read_data,
    output logic                          data_ready,
    output logic [msr_pkg::COUNT_W-1:0]   frames_received
);

    import msr_pkg::*;

    // Collection status held in flip-flops.
    frame_mask_t  frame_mask_reg  [PHASES];
    frame_mask_t  frame_mask_next [PHASES];
    frame_count_t frame_count_reg [PHASES];
    frame_count_t frame_count_next[PHASES];
    logic         ready_reg, ready_next;
    logic         snap_taken_reg, snap_taken_next;

    // Copy sweep from the collection RAM into the snapshot RAM.
    logic              copy_rd_reg, copy_rd_next;
    logic [CNT_W-1:0]  copy_cnt_reg, copy_cnt_next;
    logic              copy_wr_reg;
    logic [ADDR_W-1:0] copy_wr_addr_reg;
    logic              copy_busy;

    // First pipeline stage: result fields apart from the RAM read data.
    logic               s1_valid_reg;
    logic               s1_ready_reg;
    logic [COUNT_W-1:0] s1_frames_reg;
    logic               s1_rd_reg;
    logic               s1_adv;

    // Output register.
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_ready_reg;
    logic [COUNT_W-1:0] out_frames_reg;

    // Decoded item.
    logic              accept;
    logic              pvalid;
    logic [PH_W-1:0]   p;
    logic              seq_ok;
    logic [FIDX_W-1:0] fidx;
    frame_mask_t       frame_bit;
    logic [IDX_W-1:0]  idx;
    logic              slot_ok;
    logic              taking;
    logic              store_en;
    logic [ADDR_W-1:0] store_addr;
    logic              full_next;
    logic              rd_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic              start_copy;
    logic [COUNT_W-1:0] frames_result;

    logic [DATA_W-1:0] collect_q;
    logic [DATA_W-1:0] snap_q;

    assign copy_busy  = copy_rd_reg || copy_wr_reg;
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = copy_busy || (s1_valid_reg && !s1_adv);
    assign accept     = item_valid && !item_stall;

    // Field decode and address arithmetic.
    always_comb
    begin
        pvalid    = (phase >= BYTE_W'(1)) && (phase <= BYTE_W'(PHASES));
        p         = pvalid ? PH_W'(phase - BYTE_W'(1)) : '0;
        seq_ok    = (sequence_req >= BYTE_W'(1)) && (sequence_req <= BYTE_W'(FRAMES_PER_PHASE));
        fidx      = FIDX_W'(sequence_req - BYTE_W'(1));
        frame_bit = frame_mask_t'(1) << fidx;
        idx       = IDX_W'(IDX_W'(sequence_req - BYTE_W'(1)) * IDX_W'(SLOTS_PER_FRAME))
                    + IDX_W'(slot);
        if (sequence_req == BYTE_W'(FRAMES_PER_PHASE))
        begin
            slot_ok = (int'(slot) < LAST_FRAME_SLOTS);
        end
        else
        begin
            slot_ok = (int'(slot) < SLOTS_PER_FRAME);
        end
        store_addr = phase_base(p) + ADDR_W'(idx);
        rd_addr    = phase_base(p) + ADDR_W'(read_index);
    end

    // Next collection status and result fields for the accepted beat.
    always_comb
    begin
        frame_mask_next  = frame_mask_reg;
        frame_count_next = frame_count_reg;
        ready_next       = ready_reg;
        snap_taken_next  = snap_taken_reg;
        taking           = 1'b0;
        store_en         = 1'b0;
        start_copy       = 1'b0;
        rd_ok            = 1'b0;
        full_next        = 1'b1;

        if (accept)
        begin
            case (kind_t'(kind))
                KIND_SAMPLE:
                begin
                    taking   = pvalid && seq_ok && ((frame_mask_reg[p] & frame_bit) == '0);
                    store_en = taking && slot_ok && (int'(idx) < SAMPLES_PER_PHASE);
                    if (taking && last_of_frame)
                    begin
                        frame_mask_next[p]  = frame_mask_reg[p] | frame_bit;
                        frame_count_next[p] = frame_count_reg[p] + COUNT_W'(1);
                    end
                    for (int i = 0; i < PHASES; i++)
                    begin
                        if (frame_mask_next[i] != '1)
                        begin
                            full_next = 1'b0;
                        end
                    end
                    // The collection cannot change while every frame is marked, so
                    // only the first completion after a restart needs a copy.
                    if (full_next)
                    begin
                        ready_next = 1'b1;
                        if (!ready_reg)
                        begin
                            start_copy      = 1'b1;
                            snap_taken_next = 1'b1;
                        end
                    end
                end
                KIND_RESTART:
                begin
                    for (int i = 0; i < PHASES; i++)
                    begin
                        frame_mask_next[i]  = '0;
                        frame_count_next[i] = '0;
                    end
                    ready_next = 1'b0;
                end
                KIND_READ:
                begin
                    rd_ok = pvalid && (int'(read_index) < SAMPLES_PER_PHASE) && snap_taken_reg;
                end
                default:
                begin
                end
            endcase
        end

        frames_result = pvalid ? frame_count_next[p] : '0;
    end

    // Copy sweep counter.
    always_comb
    begin
        copy_rd_next  = copy_rd_reg;
        copy_cnt_next = copy_cnt_reg;
        if (start_copy)
        begin
            copy_rd_next  = 1'b1;
            copy_cnt_next = '0;
        end
        else if (copy_rd_reg)
        begin
            copy_cnt_next = copy_cnt_reg + CNT_W'(1);
            if (copy_cnt_reg == CNT_W'(STORE_DEPTH - 1))
            begin
                copy_rd_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PHASES; i++)
            begin
                frame_mask_reg[i]  <= '0;
                frame_count_reg[i] <= '0;
            end
            ready_reg      <= 1'b0;
            snap_taken_reg <= 1'b0;
            copy_rd_reg    <= 1'b0;
            copy_cnt_reg   <= '0;
            copy_wr_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_mask_reg  <= frame_mask_next;
            frame_count_reg <= frame_count_next;
            ready_reg       <= ready_next;
            snap_taken_reg  <= snap_taken_next;
            copy_rd_reg     <= copy_rd_next;
            copy_cnt_reg    <= copy_cnt_next;
            copy_wr_reg     <= copy_rd_reg;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        copy_wr_addr_reg <= copy_cnt_reg[ADDR_W-1:0];
        if (accept)
        begin
            s1_ready_reg  <= ready_next;
            s1_frames_reg <= frames_result;
            s1_rd_reg     <= rd_ok;
        end
        if (s1_adv)
        begin
            out_data_reg   <= s1_rd_reg ? snap_q : '0;
            out_ready_reg  <= s1_ready_reg;
            out_frames_reg <= s1_frames_reg;
        end
    end

    msr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_collect_ram (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (store_addr),
        .wr_data (sample),
        .rd_en   (copy_rd_reg),
        .rd_addr (copy_cnt_reg[ADDR_W-1:0]),
        .rd_data (collect_q)
    );

    msr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_snapshot_ram (
        .clk     (clk),
        .wr_en   (copy_wr_reg),
        .wr_addr (copy_wr_addr_reg),
        .wr_data (collect_q),
        .rd_en   (rd_ok),
        .rd_addr (rd_addr),
        .rd_data (snap_q)
    );

    assign result_valid    = out_valid_reg;
    assign read_data       = out_data_reg;
    assign data_ready      = out_ready_reg;
    assign frames_received = out_frames_reg;

endmodule

>>> rtl/msr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module msr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 600
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
